### src/tbsg_pkg.sv
// ----------------------------------------------------------------------------
// Tone burst sample generator package
// Shared constants, burst schedule and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package tbsg_pkg;

    // Stream field widths.
    localparam int unsigned FRAME_W = 24;
    localparam int unsigned CODE_W  = 24;
    localparam int unsigned EVENT_W = 3;

    // Burst schedule.
    localparam int unsigned NUM_EVENTS          = 6;
    localparam int unsigned DEFAULT_TONE_LENGTH = 1440;
    localparam logic [FRAME_W-1:0] PREROLL_FRAMES = 24'd480000;
    localparam logic [FRAME_W-1:0] BURST_BEGIN [NUM_EVENTS] = '{
        PREROLL_FRAMES + 24'd48000,  PREROLL_FRAMES + 24'd112800,
        PREROLL_FRAMES + 24'd196800, PREROLL_FRAMES + 24'd321600,
        PREROLL_FRAMES + 24'd487200, PREROLL_FRAMES + 24'd710400
    };

    // Envelope ramp length in frames.
    localparam logic [5:0] RAMP_FRAMES = 6'd48;
    localparam int unsigned ENV_W = 12;

    // Phase step per frame is (f / 20): base, per event and fixture offsets.
    localparam int unsigned STEP_W = 8;
    localparam logic [STEP_W-1:0] STEP_BASE    = 8'd33;
    localparam logic [STEP_W-1:0] STEP_EVENT   = 8'd11;
    localparam logic [STEP_W-1:0] STEP_FIXTURE = 8'd110;

    // Phase wheel: one full turn is four quarters of the sine table.
    localparam int unsigned SINE_QUARTER_ENTRIES = 600;
    localparam int unsigned PHASE_W    = 12;
    localparam logic [PHASE_W-1:0] QUARTER_WAVE = 12'd600;
    localparam logic [PHASE_W-1:0] HALF_WAVE    = 12'd1200;
    localparam logic [PHASE_W-1:0] THREEQ_WAVE  = 12'd1800;
    localparam logic [PHASE_W-1:0] FULL_WAVE    = 12'd2400;
    localparam int unsigned ROM_ADDR_W = $clog2(SINE_QUARTER_ENTRIES + 1);

    // Reciprocal for the phase reduction modulo the full wave (2^32 / 2400).
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_2400_W = 21;
    localparam logic [RECIP_2400_W-1:0] RECIP_2400 = 21'd1789569;

    // Output scaling: code = floor((env * sine * FS + BIAS) / (11520 * 2^30)).
    // The divisor is 45 * 2^38: a shift, then a reciprocal divide by 45.
    localparam int unsigned SINE_W    = 31;
    localparam int unsigned SCALE_W   = 23;
    localparam int unsigned SF_W      = SINE_W + SCALE_W;
    localparam int unsigned NUM_W     = 66;
    localparam int unsigned NUM_SHIFT = 38;
    localparam int unsigned V_W       = NUM_W - NUM_SHIFT;
    localparam int unsigned MAG_W     = 22;
    localparam logic [SCALE_W-1:0] FULL_SCALE = 23'd8388607;
    localparam logic [NUM_W-1:0]   ROUND_BIAS = 66'd45 << 37;
    localparam int unsigned RECIP_45_W = 27;
    localparam logic [RECIP_45_W-1:0] RECIP_45 = 27'd95443717;
    localparam logic [V_W-1:0] DIV_45 = 28'd45;

    // Fixed point constants for the table series.
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q40  = 64'h3243F6A8886;
    localparam logic [63:0] TABLE_SPAN = 64'(2 * SINE_QUARTER_ENTRIES);

    typedef logic [SINE_W-1:0] sine_table_t [SINE_QUARTER_ENTRIES + 1];

    // Sine of k quarter-table steps in Q30, evaluated by a nested Taylor series.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = ((64'(k) * PI_Q40) / TABLE_SPAN + 64'd512) >> 10;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd272;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return SINE_W'((x * t) >> 30);
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int unsigned k = 0; k <= SINE_QUARTER_ENTRIES; k++) begin
            tbl[k] = sine_entry(k);
        end
        return tbl;
    endfunction

    localparam sine_table_t QUARTER_SINE = build_sine_table();

endpackage

### src/tone_burst_sample_generator.sv
// ----------------------------------------------------------------------------
// Tone burst sample generator
// Maps an audio frame index to a 24-bit sample code of a scheduled tone burst.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tdata[23:0] frame_index
//  m_       | out       | tdata[23:0] sample_code, tuser[0] tone_active,
//           |           | tuser[3:1] event_number
//  cfg_wr_  | in        | data[0] fixture_select, written when cfg_wr_en is high
//
// One transfer is accepted per cycle unless the output stalls. The ten register
// stages advance together whenever the output register is empty or its result
// is taken, so a stall at the output freezes every stage and s_tready falls in
// the same cycle.
// Reset is synchronous and active low: it clears the stage valid bits and
// sets fixture_select to zero. The sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
module tone_burst_sample_generator #(
    parameter int unsigned TONE_LENGTH = tbsg_pkg::DEFAULT_TONE_LENGTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write.
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,     // [0] fixture_select
    // Frame index stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tbsg_pkg::FRAME_W-1:0] s_tdata,        // [23:0] frame_index
    // Sample stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tbsg_pkg::CODE_W-1:0]  m_tdata,        // [23:0] sample_code
    output logic [3:0]                  m_tuser          // [0] tone_active,
                                                         // [3:1] event_number
);
    import tbsg_pkg::*;

    localparam int unsigned DELTA_W = $clog2(TONE_LENGTH);
    localparam int unsigned PROD_W  = DELTA_W + STEP_W;
    localparam int unsigned QH_W    = PROD_W - 11;
    localparam int unsigned RECIP_P_W = PROD_W + RECIP_2400_W;
    localparam int unsigned NUM_STAGES = 10;
    localparam logic [FRAME_W-1:0] TONE_LEN_F = FRAME_W'(TONE_LENGTH);
    localparam logic [DELTA_W:0]   TONE_LEN_D = (DELTA_W + 1)'(TONE_LENGTH);

    typedef struct packed {
        logic               active;
        logic [EVENT_W-1:0] event_number;
    } tag_t;

    logic advance;
    logic fixture_select_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    tag_t tag_reg [NUM_STAGES];

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixture_select_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            fixture_select_reg <= cfg_wr_data;
        end
    end

    // Whole pipeline moves when the output register can take a new result.
    assign advance  = !valid_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = advance;

    // Valid bits shift with the data.
    assign valid_next = {valid_reg[NUM_STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: find the burst that holds the frame and the offset into it.
    tag_t               tag1_next;
    logic [DELTA_W-1:0] delta1_next;
    logic [DELTA_W-1:0] delta1_reg;

    always_comb begin
        logic [FRAME_W-1:0] diff;
        tag1_next   = '0;
        delta1_next = '0;
        for (int e = 0; e < NUM_EVENTS; e++) begin
            diff = s_tdata - BURST_BEGIN[e];
            if (s_tdata >= BURST_BEGIN[e] && diff < TONE_LEN_F) begin
                tag1_next.active       = 1'b1;
                tag1_next.event_number = EVENT_W'(e);
                delta1_next            = diff[DELTA_W-1:0];
            end
        end
    end

    // Stage 2: phase product and envelope product.
    logic [STEP_W-1:0]  step2;
    logic [PROD_W-1:0]  prod2_next;
    logic [DELTA_W:0]   left2;
    logic [5:0]         up2;
    logic [5:0]         down2;
    logic [ENV_W-1:0]   env2_next;
    logic [PROD_W-1:0]  prod2_reg;
    logic [ENV_W-1:0]   env2_reg;

    always_comb begin
        step2 = STEP_BASE + STEP_W'(tag_reg[0].event_number) * STEP_EVENT
              + (fixture_select_reg ? STEP_FIXTURE : '0);
        prod2_next = PROD_W'(step2) * PROD_W'(delta1_reg);
        left2 = TONE_LEN_D - {1'b0, delta1_reg};
        up2   = (delta1_reg < DELTA_W'(RAMP_FRAMES)) ? 6'(delta1_reg) : RAMP_FRAMES;
        down2 = (left2 < (DELTA_W + 1)'(RAMP_FRAMES)) ? 6'(left2) : RAMP_FRAMES;
        env2_next = ENV_W'(up2) * ENV_W'(down2);
    end

    // Stage 3: quotient estimate of the phase product by the full wave.
    logic [RECIP_P_W-1:0] recip3;
    logic [QH_W-1:0]      qh3_reg;
    logic [PROD_W-1:0]    prod3_reg;
    logic [ENV_W-1:0]     env3_reg;

    assign recip3 = RECIP_P_W'(prod2_reg) * RECIP_P_W'(RECIP_2400);

    // Stage 4: remainder with one correction step gives the phase.
    logic [PROD_W-1:0]  rem4;
    logic [PHASE_W-1:0] phase4_next;
    logic [PHASE_W-1:0] phase4_reg;
    logic [ENV_W-1:0]   env4_reg;

    always_comb begin
        rem4 = prod3_reg - PROD_W'(qh3_reg * FULL_WAVE);
        if (rem4 >= PROD_W'(FULL_WAVE)) begin
            phase4_next = PHASE_W'(rem4 - PROD_W'(FULL_WAVE));
        end else begin
            phase4_next = PHASE_W'(rem4);
        end
    end

    // Stage 5: split the phase into quadrant and table address.
    logic [PHASE_W-1:0]    offset5;
    logic [1:0]            quadrant5;
    logic [ROM_ADDR_W-1:0] addr5_next;
    logic [ROM_ADDR_W-1:0] addr5_reg;
    logic                  neg5_reg;
    logic [ENV_W-1:0]      env5_reg;

    always_comb begin
        if (phase4_reg >= THREEQ_WAVE) begin
            quadrant5 = 2'd3;
            offset5   = phase4_reg - THREEQ_WAVE;
        end else if (phase4_reg >= HALF_WAVE) begin
            quadrant5 = 2'd2;
            offset5   = phase4_reg - HALF_WAVE;
        end else if (phase4_reg >= QUARTER_WAVE) begin
            quadrant5 = 2'd1;
            offset5   = phase4_reg - QUARTER_WAVE;
        end else begin
            quadrant5 = 2'd0;
            offset5   = phase4_reg;
        end
        // Odd quadrants walk the table backward.
        if (quadrant5[0]) begin
            addr5_next = ROM_ADDR_W'(QUARTER_WAVE - offset5);
        end else begin
            addr5_next = ROM_ADDR_W'(offset5);
        end
    end

    // Stage 6: sine table read.
    logic [SINE_W-1:0] sine6;
    logic              neg6_reg;
    logic [ENV_W-1:0]  env6_reg;

    tbsg_sine_rom u_sine_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (addr5_reg),
        .rd_data (sine6)
    );

    // Stage 7: sine times full scale.
    logic [SF_W-1:0]  sf7_reg;
    logic             neg7_reg;
    logic [ENV_W-1:0] env7_reg;

    // Stage 8: times envelope plus rounding bias.
    logic [NUM_W-1:0] num8_reg;
    logic             neg8_reg;

    // Stage 9: divide the shifted numerator by 45 with a reciprocal.
    logic [V_W-1:0]   v9;
    logic [V_W+RECIP_45_W-1:0] recip9;
    logic [MAG_W-1:0] q9_reg;
    logic [V_W-1:0]   v9_reg;
    logic             neg9_reg;

    assign v9     = num8_reg[NUM_W-1:NUM_SHIFT];
    assign recip9 = (V_W + RECIP_45_W)'(v9) * (V_W + RECIP_45_W)'(RECIP_45);

    // Stage 10: quotient correction, sign and the output register.
    logic [V_W-1:0]    rem10;
    logic [MAG_W-1:0]  mag10;
    logic [CODE_W-1:0] code10_next;
    logic [CODE_W-1:0] code10_reg;

    always_comb begin
        rem10 = v9_reg - V_W'(q9_reg * DIV_45);
        mag10 = (rem10 >= DIV_45) ? q9_reg + 1'b1 : q9_reg;
        if (!tag_reg[8].active) begin
            code10_next = '0;
        end else if (neg9_reg) begin
            code10_next = CODE_W'(0) - CODE_W'(mag10);
        end else begin
            code10_next = CODE_W'(mag10);
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            tag_reg[0] <= tag1_next;
            for (int i = 1; i < NUM_STAGES; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            delta1_reg <= delta1_next;
            prod2_reg  <= prod2_next;
            env2_reg   <= env2_next;
            qh3_reg    <= QH_W'(recip3 >> RECIP_SHIFT);
            prod3_reg  <= prod2_reg;
            env3_reg   <= env2_reg;
            phase4_reg <= phase4_next;
            env4_reg   <= env3_reg;
            addr5_reg  <= addr5_next;
            neg5_reg   <= quadrant5[1];
            env5_reg   <= env4_reg;
            neg6_reg   <= neg5_reg;
            env6_reg   <= env5_reg;
            sf7_reg    <= SF_W'(sine6) * SF_W'(FULL_SCALE);
            neg7_reg   <= neg6_reg;
            env7_reg   <= env6_reg;
            num8_reg   <= NUM_W'(sf7_reg) * NUM_W'(env7_reg) + ROUND_BIAS;
            neg8_reg   <= neg7_reg;
            q9_reg     <= recip9[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
            v9_reg     <= v9;
            neg9_reg   <= neg8_reg;
            code10_reg <= code10_next;
        end
    end

    // Result channel.
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = code10_reg;
    assign m_tuser  = {tag_reg[NUM_STAGES-1].event_number, tag_reg[NUM_STAGES-1].active};

endmodule

### src/tbsg_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Holds sin(0..pi/2) in Q30 with a registered read port.
// ----------------------------------------------------------------------------
module tbsg_sine_rom (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [tbsg_pkg::ROM_ADDR_W-1:0] rd_addr,
    output logic [tbsg_pkg::SINE_W-1:0]     rd_data
);
    import tbsg_pkg::*;

    logic [SINE_W-1:0] rd_data_reg;

    // Registered read; the read holds while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= QUARTER_SINE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
